>>> sv/mrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants of the meter reading scaler: reading kinds,
// register indexes, item layouts and the sizes of the frequency divider.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Metering chip clock and the frequency numerator built from it
  localparam longint unsigned CHIP_CLOCK_HZ = 64'd3579545;
  localparam longint unsigned FREQ_NUM      = CHIP_CLOCK_HZ * 64;
  // Quotient bits: the numerator never reaches FREQ_NUM + 65536
  localparam int unsigned     NUM_W         = $clog2(FREQ_NUM + 64'd65536);
  // Divisor is twice a 16-bit count
  localparam int unsigned     DEN_W         = 17;
  // Multiplier unit latency in cycles
  localparam int unsigned     MUL_LAT       = 3;

  localparam logic [31:0]     GAIN_ONE      = 32'h0100_0000;

  typedef enum logic [2:0] {
    KIND_VOLTAGE   = 3'd0,
    KIND_CURRENT_A = 3'd1,
    KIND_CURRENT_B = 3'd2,
    KIND_POWER_A   = 3'd3,
    KIND_POWER_B   = 3'd4,
    KIND_FREQ      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_VOLTAGE_GAIN   = 3'd0,
    REG_CURRENT_A_GAIN = 3'd1,
    REG_CURRENT_B_GAIN = 3'd2,
    REG_POWER_A_GAIN   = 3'd3,
    REG_POWER_B_GAIN   = 3'd4,
    REG_VOLTAGE_ZERO   = 3'd5,
    REG_CURRENT_A_ZERO = 3'd6,
    REG_CURRENT_B_ZERO = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] raw_reading;
  } mrs_in_t;

  typedef struct packed {
    logic signed [47:0] scaled_value;
    logic               value_valid;
  } mrs_out_t;

  // Operand pair for the scaling multiplier
  typedef struct packed {
    logic signed [32:0] operand;
    logic [31:0]        gain;
  } mrs_mul_op_t;

  // Operand pair for the frequency divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mrs_div_op_t;

  // Control that travels alongside each item
  typedef struct packed {
    logic valid;
    logic freq;
    logic freq_zero;
  } mrs_ctl_t;

endpackage

>>> sv/mrs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_mul
// Pipelined signed-by-Q8.24 multiplier with round-to-nearest (ties up) to
// Q.8. Three stages: half-width partial products, sum, rounding.
// ----------------------------------------------------------------------------
module mrs_mul
  import mrs_pkg::*;
(
  input  logic               clk,
  input  mrs_mul_op_t        op,
  output logic signed [47:0] value
);

  logic signed [16:0] gain_lo;
  logic signed [16:0] gain_hi;
  logic signed [49:0] pp_lo;
  logic signed [49:0] pp_hi;
  logic signed [65:0] prod;
  logic signed [65:0] prod_next;
  logic signed [65:0] rnd;

  assign gain_lo = $signed({1'b0, op.gain[15:0]});
  assign gain_hi = $signed({1'b0, op.gain[31:16]});

  // Form the two partial products
  always_ff @(posedge clk) begin
    pp_lo <= op.operand * gain_lo;
    pp_hi <= op.operand * gain_hi;
  end

  // Add the partial products
  assign prod_next = {{16{pp_hi[49]}}, pp_hi} * 66'sd65536
                   + {{16{pp_lo[49]}}, pp_lo};

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  // Round to Q.8: add half a step, drop 16 fraction bits
  assign rnd = prod + 66'sh8000;

  always_ff @(posedge clk) begin
    value <= rnd[63:16];
  end

endmodule

>>> sv/mrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_div
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// A zero divisor gives a meaningless quotient that the caller discards.
// ----------------------------------------------------------------------------
module mrs_div
  import mrs_pkg::*;
(
  input  logic             clk,
  input  mrs_div_op_t      op,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] num [NUM_W];
  logic [DEN_W-1:0] den [NUM_W];
  logic [DEN_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] q   [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign num_in = op.num;
      assign den_in = op.den;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_rest
      assign num_in = num[k-1];
      assign den_in = den[k-1];
      assign rem_in = rem[k-1];
      assign q_in   = q[k-1];
    end

    // Bring down the next numerator bit and try the subtract
    assign trial = {rem_in, num_in[NUM_W-1-k]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      num[k] <= num_in;
      den[k] <= den_in;
      rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q[k]   <= {q_in[NUM_W-2:0], ge};
    end
  end

  assign quot = q[NUM_W-1];

endmodule

>>> sv/meter_reading_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_reading_scaler
// Scales raw energy-meter readings (RMS voltage and currents, active power,
// line frequency) to signed Q.8 values.
// ----------------------------------------------------------------------------
// Usage: the block takes one item in every clock cycle (busy stays low) and
// gives each result on result with done high for exactly one cycle, in the
// order the items went in, after the decode register, the divider or
// multiplier stages and the result register. The frequency divider sets
// the depth, one quotient bit per stage; readings of every kind pass
// through the same depth so that order is kept. There is no back-pressure:
// the receiver must take each result in the cycle it appears. Write the
// gain and zero registers only while no item is in flight.
// ----------------------------------------------------------------------------
module meter_reading_scaler
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  mrs_in_t     item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output mrs_out_t    result
);

  localparam int unsigned DLY_N = NUM_W - MUL_LAT;

  // Configuration registers
  logic [31:0] voltage_gain;
  logic [31:0] current_a_gain;
  logic [31:0] current_b_gain;
  logic [31:0] power_a_gain;
  logic [31:0] power_b_gain;
  logic [22:0] voltage_zero;
  logic [22:0] current_a_zero;
  logic [22:0] current_b_zero;

  // Decode stage
  logic [22:0]        zero_sel;
  logic [23:0]        rms_diff;
  logic               rms_pos;
  logic [15:0]        freq_raw;
  mrs_mul_op_t        mul_op_next;
  mrs_mul_op_t        mul_op;
  mrs_div_op_t        div_op;
  mrs_ctl_t           ctl_next;
  mrs_ctl_t           ctl [NUM_W+1];

  // Unit outputs and alignment
  logic signed [47:0] mul_value;
  logic signed [47:0] dly [DLY_N];
  logic [NUM_W-1:0]   quot;
  mrs_out_t           result_next;

  // The pipeline never stalls
  assign busy = 1'b0;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain   <= GAIN_ONE;
      current_a_gain <= GAIN_ONE;
      current_b_gain <= GAIN_ONE;
      power_a_gain   <= GAIN_ONE;
      power_b_gain   <= GAIN_ONE;
      voltage_zero   <= '0;
      current_a_zero <= '0;
      current_b_zero <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_VOLTAGE_GAIN:   voltage_gain   <= cfg_data;
        REG_CURRENT_A_GAIN: current_a_gain <= cfg_data;
        REG_CURRENT_B_GAIN: current_b_gain <= cfg_data;
        REG_POWER_A_GAIN:   power_a_gain   <= cfg_data;
        REG_POWER_B_GAIN:   power_b_gain   <= cfg_data;
        REG_VOLTAGE_ZERO:   voltage_zero   <= cfg_data[22:0];
        REG_CURRENT_A_ZERO: current_a_zero <= cfg_data[22:0];
        REG_CURRENT_B_ZERO: current_b_zero <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // Pick the offset for an RMS item and subtract it
  always_comb begin
    case (kind_t'(item.action))
      KIND_CURRENT_A: zero_sel = current_a_zero;
      KIND_CURRENT_B: zero_sel = current_b_zero;
      default:        zero_sel = voltage_zero;
    endcase
  end

  assign rms_diff = {1'b0, item.raw_reading[22:0]} - {1'b0, zero_sel};
  // Invalid mark clear, and reading strictly above the offset
  assign rms_pos  = !item.raw_reading[23] && !rms_diff[23] && (rms_diff[22:0] != '0);
  assign freq_raw = item.raw_reading[15:0];

  // Build the multiplier operands; unused kinds multiply zero
  always_comb begin
    mul_op_next.operand = '0;
    mul_op_next.gain    = '0;
    case (kind_t'(item.action))
      KIND_VOLTAGE: begin
        mul_op_next.operand = rms_pos ? $signed({10'b0, rms_diff[22:0]}) : '0;
        mul_op_next.gain    = voltage_gain;
      end
      KIND_CURRENT_A: begin
        mul_op_next.operand = rms_pos ? $signed({10'b0, rms_diff[22:0]}) : '0;
        mul_op_next.gain    = current_a_gain;
      end
      KIND_CURRENT_B: begin
        mul_op_next.operand = rms_pos ? $signed({10'b0, rms_diff[22:0]}) : '0;
        mul_op_next.gain    = current_b_gain;
      end
      KIND_POWER_A: begin
        mul_op_next.operand = $signed({item.raw_reading[31], item.raw_reading});
        mul_op_next.gain    = power_a_gain;
      end
      KIND_POWER_B: begin
        mul_op_next.operand = $signed({item.raw_reading[31], item.raw_reading});
        mul_op_next.gain    = power_b_gain;
      end
      default: ;
    endcase
  end

  assign ctl_next.valid     = start && !busy;
  assign ctl_next.freq      = (kind_t'(item.action) == KIND_FREQ);
  assign ctl_next.freq_zero = (freq_raw == '0);

  // Register the decoded item
  always_ff @(posedge clk) begin
    mul_op     <= mul_op_next;
    div_op.num <= NUM_W'(FREQ_NUM) + NUM_W'(freq_raw);
    div_op.den <= {freq_raw, 1'b0};
  end

  // Carry control alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_W; i++) begin
        ctl[i] <= '0;
      end
    end else begin
      ctl[0] <= ctl_next;
      for (int i = 1; i <= NUM_W; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  mrs_mul u_mul (
    .clk   (clk),
    .op    (mul_op),
    .value (mul_value)
  );

  mrs_div u_div (
    .clk  (clk),
    .op   (div_op),
    .quot (quot)
  );

  // Hold scaled values until the divider catches up
  always_ff @(posedge clk) begin
    dly[0] <= mul_value;
    for (int i = 1; i < DLY_N; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  // Select the result for the item at the end of the line
  always_comb begin
    result_next.scaled_value = dly[DLY_N-1];
    result_next.value_valid  = 1'b1;
    if (ctl[NUM_W].freq) begin
      if (ctl[NUM_W].freq_zero) begin
        result_next.scaled_value = '0;
        result_next.value_valid  = 1'b0;
      end else begin
        result_next.scaled_value = $signed(48'(quot));
      end
    end
  end

  // Drive the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[NUM_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
